// ===== src/cor_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cor_pkg
// Shared types, widths and angle constants for the camera offset rotator.
// ----------------------------------------------------------------------------
package cor_pkg;

   localparam int Q_W    = 32;              // coordinate width, q16.16
   localparam int A_W    = 20;              // input angle width, q3.16
   localparam int REQ_W  = 216;             // six coordinates and the angle, byte padded
   localparam int RSP_W  = 104;             // three coordinates, byte padded
   localparam int SQ_W   = 64;              // sum of squares
   localparam int RT_W   = 32;              // integer root
   localparam int XW     = 54;              // cordic x and y
   localparam int ZW     = 36;              // angles, q30 radians
   localparam int CW     = 34;              // sine and cosine
   localparam int GW     = 35;              // rounded q30 products and new offsets
   localparam int PW     = 68;              // full products
   localparam int STEPS  = 32;              // cordic iterations

   localparam logic signed [ZW-1:0] HALF_PI_Q30   = ZW'(64'sd1686629713);
   localparam logic signed [ZW-1:0] PI_Q30        = ZW'(64'sd3373259426);
   localparam logic signed [ZW-1:0] TWO_PI_Q30    = ZW'(64'sd6746518852);
   localparam logic signed [ZW-1:0] POLAR_EPS_Q30 = ZW'(64'sd10737);
   localparam logic signed [XW-1:0] CORDIC_GAIN_Q30 = XW'(64'sh26DD3B6A);

   typedef enum logic [1:0] {
      CMD_YAW   = 2'd0,
      CMD_ELEV  = 2'd1,
      CMD_POLAR = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type                 cmd;
      logic signed [Q_W-1:0]   ox;
      logic signed [Q_W-1:0]   oy;
      logic signed [Q_W-1:0]   oz;
      logic signed [Q_W-1:0]   ax;
      logic signed [Q_W-1:0]   ay;
      logic signed [Q_W-1:0]   az;
      logic signed [ZW-1:0]    ang;
      logic                    degen;
      logic [RT_W-1:0]         r;
   } pay_type;

   function automatic logic signed [ZW-1:0] cor_atan(input int unsigned idx);
      logic [31:0] v;
      case (idx)
         0:  v = 32'h3243F6A8;
         1:  v = 32'h1DAC6705;
         2:  v = 32'h0FADBAFC;
         3:  v = 32'h07F56EA6;
         4:  v = 32'h03FEAB76;
         5:  v = 32'h01FFD55B;
         6:  v = 32'h00FFFAAA;
         7:  v = 32'h007FFF55;
         8:  v = 32'h003FFFEA;
         9:  v = 32'h001FFFFD;
         10: v = 32'h000FFFFF;
         11: v = 32'h0007FFFF;
         12: v = 32'h0003FFFF;
         13: v = 32'h0001FFFF;
         14: v = 32'h0000FFFF;
         15: v = 32'h00007FFF;
         16: v = 32'h00003FFF;
         17: v = 32'h00001FFF;
         18: v = 32'h00000FFF;
         19: v = 32'h000007FF;
         20: v = 32'h000003FF;
         21: v = 32'h000001FF;
         22: v = 32'h000000FF;
         23: v = 32'h0000007F;
         24: v = 32'h0000003F;
         25: v = 32'h0000001F;
         26: v = 32'h0000000F;
         27: v = 32'h00000008;
         28: v = 32'h00000004;
         29: v = 32'h00000002;
         30: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return ZW'(v);
   endfunction

endpackage
`default_nettype wire

// ===== src/cor_isqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cor_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module cor_isqrt (
   input  wire logic                      clock,
   input  wire logic                      en,
   input  wire logic [cor_pkg::SQ_W-1:0]  n_i,
   output logic [cor_pkg::RT_W-1:0]       root_o
);
   import cor_pkg::*;

   logic [SQ_W-1:0] rem_ff [0:RT_W-1];
   logic [SQ_W-1:0] rem_in [0:RT_W-1];
   logic [RT_W-1:0] res_ff [0:RT_W-1];
   logic [RT_W-1:0] res_in [0:RT_W-1];

   for (genvar j = 0; j < RT_W; j++) begin : g_bit
      localparam int K = RT_W - 1 - j;
      logic [SQ_W-1:0] rem_prev;
      logic [RT_W-1:0] res_prev;
      logic [SQ_W+1:0] trial;
      logic            fits;

      if (j == 0) begin : g_first
         assign rem_prev = n_i;
         assign res_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign res_prev = res_ff[j-1];
      end

      assign trial = ((SQ_W+2)'(res_prev) << (K + 1)) | ((SQ_W+2)'(1) << (2 * K));
      assign fits  = (SQ_W+2)'(rem_prev) >= trial;
      assign rem_in[j] = fits ? rem_prev - trial[SQ_W-1:0] : rem_prev;
      assign res_in[j] = fits ? (res_prev | (RT_W'(1) << K)) : res_prev;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         res_ff <= res_in;
      end
   end

   assign root_o = res_ff[RT_W-1];

endmodule
`default_nettype wire

// ===== src/cor_cordic.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cor_cordic
// Pipelined cordic: vectoring gives atan2, rotation gives cosine and sine.
// ----------------------------------------------------------------------------
module cor_cordic (
   input  wire logic                           clock,
   input  wire logic                           en,
   input  wire logic                           vectoring,
   input  wire logic signed [cor_pkg::XW-1:0]  x_i,
   input  wire logic signed [cor_pkg::XW-1:0]  y_i,
   input  wire logic signed [cor_pkg::ZW-1:0]  z_i,
   output logic signed [cor_pkg::XW-1:0]       x_o,
   output logic signed [cor_pkg::XW-1:0]       y_o,
   output logic signed [cor_pkg::ZW-1:0]       z_o
);
   import cor_pkg::*;

   logic signed [XW-1:0] x_ff [0:STEPS];
   logic signed [XW-1:0] x_in [0:STEPS];
   logic signed [XW-1:0] y_ff [0:STEPS];
   logic signed [XW-1:0] y_in [0:STEPS];
   logic signed [ZW-1:0] z_ff [0:STEPS];
   logic signed [ZW-1:0] z_in [0:STEPS];
   logic [STEPS:0]       flag_ff;
   logic [STEPS:0]       flag_in;
   logic [STEPS-1:0]     dir_pos;
   logic signed [XW-1:0] xo_ff, xo_in, yo_ff, yo_in;
   logic signed [ZW-1:0] zo_ff, zo_in;

   always_comb begin
      // pre stage: half turn for vectoring, fold into +-pi/2 for rotation
      x_in[0]    = x_i;
      y_in[0]    = y_i;
      z_in[0]    = '0;
      flag_in[0] = 1'b0;
      if (vectoring) begin
         flag_in[0] = (x_i == '0) && (y_i == '0);
         if (x_i < 0) begin
            x_in[0] = -x_i;
            y_in[0] = -y_i;
            z_in[0] = (y_i >= 0) ? PI_Q30 : -PI_Q30;
         end
      end else begin
         x_in[0] = CORDIC_GAIN_Q30;
         y_in[0] = '0;
         z_in[0] = z_i;
         if (z_i > HALF_PI_Q30) begin
            z_in[0]    = z_i - PI_Q30;
            flag_in[0] = 1'b1;
         end else if (z_i < -HALF_PI_Q30) begin
            z_in[0]    = z_i + PI_Q30;
            flag_in[0] = 1'b1;
         end
      end
      // iteration stages
      for (int i = 0; i < STEPS; i++) begin
         dir_pos[i]   = vectoring ? (y_ff[i] <= 0) : (z_ff[i] >= 0);
         x_in[i+1]    = dir_pos[i] ? x_ff[i] - (y_ff[i] >>> i) : x_ff[i] + (y_ff[i] >>> i);
         y_in[i+1]    = dir_pos[i] ? y_ff[i] + (x_ff[i] >>> i) : y_ff[i] - (x_ff[i] >>> i);
         z_in[i+1]    = dir_pos[i] ? z_ff[i] - cor_atan(i) : z_ff[i] + cor_atan(i);
         flag_in[i+1] = flag_ff[i];
      end
   end

   // post stage: zero vector gives angle zero, folded angle flips the signs
   assign xo_in = (!vectoring && flag_ff[STEPS]) ? -x_ff[STEPS] : x_ff[STEPS];
   assign yo_in = (!vectoring && flag_ff[STEPS]) ? -y_ff[STEPS] : y_ff[STEPS];
   assign zo_in = (vectoring && flag_ff[STEPS]) ? '0 : z_ff[STEPS];

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         flag_ff <= flag_in;
         xo_ff   <= xo_in;
         yo_ff   <= yo_in;
         zo_ff   <= zo_in;
      end
   end

   assign x_o = xo_ff;
   assign y_o = yo_ff;
   assign z_o = zo_ff;

endmodule
`default_nettype wire

// ===== src/camera_offset_rotate_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// camera_offset_rotate_top
// Rotates a camera offset by yaw, elevation or polar angle, or passes it on, and adds the anchor.
// ----------------------------------------------------------------------------
//  channel  direction  tdata                                      tuser
//  req_     in         offset x,y,z, anchor x,y,z, angle          command
//  rsp_     out        point x,y,z                                degenerate
//
//  one beat in and one beat out per cycle while rsp_ beats are taken
//  a result passes the 32 stage root, the 34 stage atan2 cordic and the
//  34 stage sine and cosine cordic
//  reset clears only the valid bits of the pipeline
//  while rsp_ holds a beat that is not taken the whole pipeline and req_ stall
// ----------------------------------------------------------------------------
module camera_offset_rotate_top (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   // offset_x, offset_y, offset_z, anchor_x, anchor_y, anchor_z, angle, pad
   input  wire logic [cor_pkg::REQ_W-1:0]   req_tdata,
   // command
   input  wire logic [1:0]                  req_tuser,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   // point_x, point_y, point_z, pad
   output logic [cor_pkg::RSP_W-1:0]        rsp_tdata,
   // degenerate
   output logic [0:0]                       rsp_tuser
);
   import cor_pkg::*;

   localparam int CORDIC_LAT = STEPS + 2;
   localparam int ST_SQ      = 1;
   localparam int ST_SUM     = 2;
   localparam int ST_ROOT    = ST_SUM + RT_W;
   localparam int ST_ATAN    = ST_ROOT + CORDIC_LAT;
   localparam int ST_ANG     = ST_ATAN + 1;
   localparam int ST_TRIG    = ST_ANG + CORDIC_LAT;
   localparam int ST_M1      = ST_TRIG + 1;
   localparam int ST_M2      = ST_M1 + 1;
   localparam int ST_M3      = ST_M2 + 1;
   localparam int ST_M4      = ST_M3 + 1;
   localparam int ST_OUT     = ST_M4 + 1;
   localparam logic signed [PW-1:0] RND_Q30 = PW'(1) << 29;

   function automatic logic signed [XW-1:0] scale_q(input logic signed [Q_W-1:0] v);
      return {{(XW-Q_W-16){v[Q_W-1]}}, v, 16'b0};
   endfunction

   function automatic logic signed [ZW-1:0] wrap_pi(input logic signed [ZW-1:0] a);
      logic signed [ZW-1:0] w;
      w = a;
      if (a > PI_Q30) begin
         w = a - TWO_PI_Q30;
      end else if (a < -PI_Q30) begin
         w = a + TWO_PI_Q30;
      end
      return w;
   endfunction

   function automatic logic [Q_W-1:0] sat_q(input logic signed [GW:0] v);
      logic [Q_W-1:0] s;
      if (v[GW:Q_W-1] == '0 || v[GW:Q_W-1] == '1) begin
         s = v[Q_W-1:0];
      end else if (v[GW]) begin
         s = {1'b1, {(Q_W-1){1'b0}}};
      end else begin
         s = {1'b0, {(Q_W-1){1'b1}}};
      end
      return s;
   endfunction

   logic                 en;
   logic [ST_OUT:0]      valid_ff;
   pay_type              pay_ff [0:ST_OUT-1];
   pay_type              pay_in [0:ST_OUT-1];

   logic [SQ_W-1:0]      sqx_ff, sqy_ff, sqz_ff;
   logic [SQ_W-1:0]      sumr_ff, sumh_ff;
   logic [RT_W-1:0]      root_r, root_h;

   logic signed [XW-1:0] h_sc;
   logic signed [XW-1:0] ax_i, ay_i, bx_i, by_i;
   logic signed [XW-1:0] ax_o, ay_o, bx_o, by_o;
   logic signed [ZW-1:0] az_o, bz_o;
   logic signed [ZW-1:0] t_raw, ang1_in, ang2_in, ang1_ff, ang2_ff;
   logic signed [XW-1:0] cx_o, cy_o, dx_o, dy_o;
   logic signed [ZW-1:0] cz_o, dz_o;
   logic signed [CW-1:0] c1, s1, c2, s2;

   logic signed [CW-1:0] pa_l, pa_r, pb_l, pb_r;
   logic signed [PW-1:0] pa_ff, pb_ff, pc_ff, pd_ff;
   logic signed [CW-1:0] c2_ff, s2_ff;
   logic signed [PW-1:0] yx_sum, yz_sum, qa_sum, qb_sum;
   logic signed [GW-1:0] gx_in, gy_in, gz_in, gx_ff, gy_ff, gz_ff;
   logic signed [GW-1:0] yawx_ff, yawz_ff, yawx2_ff, yawz2_ff;
   logic signed [RT_W:0] r_s;
   logic signed [PW-1:0] rx_ff, ry_ff, rz_ff, rx_sum, ry_sum, rz_sum;
   logic signed [GW-1:0] nx_in, ny_in, nz_in, nx_ff, ny_ff, nz_ff;
   logic signed [GW:0]   sx, sy, sz;
   logic [Q_W-1:0]       px_ff, py_ff, pz_ff;
   logic                 dg_ff;

   assign en         = !valid_ff[ST_OUT] || rsp_tready;
   assign req_tready = en;

   // payload line
   always_comb begin
      for (int i = 1; i < ST_OUT; i++) begin
         pay_in[i] = pay_ff[i-1];
      end
      pay_in[0].cmd   = cmd_type'(req_tuser);
      pay_in[0].ox    = req_tdata[31:0];
      pay_in[0].oy    = req_tdata[63:32];
      pay_in[0].oz    = req_tdata[95:64];
      pay_in[0].ax    = req_tdata[127:96];
      pay_in[0].ay    = req_tdata[159:128];
      pay_in[0].az    = req_tdata[191:160];
      pay_in[0].ang   = {{(ZW-A_W-14){req_tdata[211]}}, req_tdata[211:192], 14'b0};
      pay_in[0].degen = (req_tdata[95:0] == '0);
      pay_in[0].r     = '0;
      pay_in[ST_ROOT+1].r = root_r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[ST_OUT-1:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pay_ff <= pay_in;
      end
   end

   // squares and sums
   always_ff @(posedge clock) begin
      if (en) begin
         sqx_ff  <= SQ_W'(pay_ff[ST_SQ-1].ox * pay_ff[ST_SQ-1].ox);
         sqy_ff  <= SQ_W'(pay_ff[ST_SQ-1].oy * pay_ff[ST_SQ-1].oy);
         sqz_ff  <= SQ_W'(pay_ff[ST_SQ-1].oz * pay_ff[ST_SQ-1].oz);
         sumr_ff <= sqx_ff + sqy_ff + sqz_ff;
         sumh_ff <= sqx_ff + ((pay_ff[ST_SUM-1].cmd == CMD_ELEV) ? sqz_ff : sqy_ff);
      end
   end

   cor_isqrt u_root_r (
      .clock  (clock),
      .en     (en),
      .n_i    (sumr_ff),
      .root_o (root_r)
   );

   cor_isqrt u_root_h (
      .clock  (clock),
      .en     (en),
      .n_i    (sumh_ff),
      .root_o (root_h)
   );

   // azimuth and elevation or polar angle
   assign h_sc = {{(XW-RT_W-16){1'b0}}, root_h, 16'b0};
   assign ax_i = scale_q(pay_ff[ST_ROOT].ox);
   assign ay_i = scale_q((pay_ff[ST_ROOT].cmd == CMD_ELEV) ? pay_ff[ST_ROOT].oz
                                                           : pay_ff[ST_ROOT].oy);
   assign bx_i = (pay_ff[ST_ROOT].cmd == CMD_ELEV) ? h_sc : scale_q(pay_ff[ST_ROOT].oz);
   assign by_i = (pay_ff[ST_ROOT].cmd == CMD_ELEV) ? scale_q(pay_ff[ST_ROOT].oy) : h_sc;

   cor_cordic u_atan_azim (
      .clock     (clock),
      .en        (en),
      .vectoring (1'b1),
      .x_i       (ax_i),
      .y_i       (ay_i),
      .z_i       ('0),
      .x_o       (ax_o),
      .y_o       (ay_o),
      .z_o       (az_o)
   );

   cor_cordic u_atan_tilt (
      .clock     (clock),
      .en        (en),
      .vectoring (1'b1),
      .x_i       (bx_i),
      .y_i       (by_i),
      .z_i       ('0),
      .x_o       (bx_o),
      .y_o       (by_o),
      .z_o       (bz_o)
   );

   // add angle and clamp, or wrap the yaw angle
   assign t_raw = bz_o + pay_ff[ST_ATAN].ang;

   always_comb begin
      ang2_in = t_raw;
      case (pay_ff[ST_ATAN].cmd)
         CMD_ELEV: begin
            if (t_raw > HALF_PI_Q30) begin
               ang2_in = HALF_PI_Q30;
            end else if (t_raw < -HALF_PI_Q30) begin
               ang2_in = -HALF_PI_Q30;
            end
         end
         CMD_POLAR: begin
            if (t_raw < POLAR_EPS_Q30) begin
               ang2_in = POLAR_EPS_Q30;
            end else if (t_raw > PI_Q30 - POLAR_EPS_Q30) begin
               ang2_in = PI_Q30 - POLAR_EPS_Q30;
            end
         end
         default: begin
            ang2_in = t_raw;
         end
      endcase
      ang1_in = (pay_ff[ST_ATAN].cmd == CMD_YAW) ? wrap_pi(pay_ff[ST_ATAN].ang) : az_o;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ang1_ff <= ang1_in;
         ang2_ff <= ang2_in;
      end
   end

   cor_cordic u_trig_azim (
      .clock     (clock),
      .en        (en),
      .vectoring (1'b0),
      .x_i       ('0),
      .y_i       ('0),
      .z_i       (ang1_ff),
      .x_o       (cx_o),
      .y_o       (cy_o),
      .z_o       (cz_o)
   );

   cor_cordic u_trig_tilt (
      .clock     (clock),
      .en        (en),
      .vectoring (1'b0),
      .x_i       ('0),
      .y_i       ('0),
      .z_i       (ang2_ff),
      .x_o       (dx_o),
      .y_o       (dy_o),
      .z_o       (dz_o)
   );

   assign c1 = cx_o[CW-1:0];
   assign s1 = cy_o[CW-1:0];
   assign c2 = dx_o[CW-1:0];
   assign s2 = dy_o[CW-1:0];

   // first products
   always_comb begin
      case (pay_ff[ST_TRIG].cmd)
         CMD_YAW: begin
            pa_l = CW'(pay_ff[ST_TRIG].ox);
            pa_r = c1;
            pb_l = CW'(pay_ff[ST_TRIG].oz);
            pb_r = s1;
         end
         CMD_ELEV: begin
            pa_l = c1;
            pa_r = c2;
            pb_l = s1;
            pb_r = c2;
         end
         default: begin
            pa_l = s2;
            pa_r = c1;
            pb_l = s2;
            pb_r = s1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff <= pa_l * pa_r;
         pb_ff <= pb_l * pb_r;
         pc_ff <= CW'(pay_ff[ST_TRIG].ox) * s1;
         pd_ff <= CW'(pay_ff[ST_TRIG].oz) * c1;
         c2_ff <= c2;
         s2_ff <= s2;
      end
   end

   // round to q30 and pick the radius factors
   assign yx_sum = pa_ff - pb_ff + RND_Q30;
   assign yz_sum = pc_ff + pd_ff + RND_Q30;
   assign qa_sum = pa_ff + RND_Q30;
   assign qb_sum = pb_ff + RND_Q30;
   assign gx_in  = qa_sum[GW+29:30];
   assign gy_in  = (pay_ff[ST_M1].cmd == CMD_ELEV) ? GW'(s2_ff) : qb_sum[GW+29:30];
   assign gz_in  = (pay_ff[ST_M1].cmd == CMD_ELEV) ? qb_sum[GW+29:30] : GW'(c2_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         gx_ff   <= gx_in;
         gy_ff   <= gy_in;
         gz_ff   <= gz_in;
         yawx_ff <= yx_sum[GW+29:30];
         yawz_ff <= yz_sum[GW+29:30];
      end
   end

   // scale by radius
   assign r_s = {1'b0, pay_ff[ST_M2].r};

   always_ff @(posedge clock) begin
      if (en) begin
         rx_ff    <= r_s * gx_ff;
         ry_ff    <= r_s * gy_ff;
         rz_ff    <= r_s * gz_ff;
         yawx2_ff <= yawx_ff;
         yawz2_ff <= yawz_ff;
      end
   end

   // select new offset
   assign rx_sum = rx_ff + RND_Q30;
   assign ry_sum = ry_ff + RND_Q30;
   assign rz_sum = rz_ff + RND_Q30;

   always_comb begin
      case (pay_ff[ST_M3].cmd)
         CMD_YAW: begin
            nx_in = yawx2_ff;
            ny_in = GW'(pay_ff[ST_M3].oy);
            nz_in = yawz2_ff;
         end
         CMD_ELEV, CMD_POLAR: begin
            nx_in = rx_sum[GW+29:30];
            ny_in = ry_sum[GW+29:30];
            nz_in = rz_sum[GW+29:30];
         end
         default: begin
            nx_in = GW'(pay_ff[ST_M3].ox);
            ny_in = GW'(pay_ff[ST_M3].oy);
            nz_in = GW'(pay_ff[ST_M3].oz);
         end
      endcase
      if (pay_ff[ST_M3].degen) begin
         nx_in = '0;
         ny_in = '0;
         nz_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nx_ff <= nx_in;
         ny_ff <= ny_in;
         nz_ff <= nz_in;
      end
   end

   // add anchor and saturate
   assign sx = (GW+1)'(nx_ff) + (GW+1)'(pay_ff[ST_M4].ax);
   assign sy = (GW+1)'(ny_ff) + (GW+1)'(pay_ff[ST_M4].ay);
   assign sz = (GW+1)'(nz_ff) + (GW+1)'(pay_ff[ST_M4].az);

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= sat_q(sx);
         py_ff <= sat_q(sy);
         pz_ff <= sat_q(sz);
         dg_ff <= pay_ff[ST_M4].degen;
      end
   end

   assign rsp_tvalid = valid_ff[ST_OUT];
   assign rsp_tdata  = {{(RSP_W-3*Q_W){1'b0}}, pz_ff, py_ff, px_ff};
   assign rsp_tuser  = dg_ff;

   a_reset_clear: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_elev_clamp: assert property (@(posedge clock) disable iff (reset)
      valid_ff[ST_ANG] && pay_ff[ST_ANG].cmd == CMD_ELEV
      |-> (ang2_ff <= HALF_PI_Q30) && (ang2_ff >= -HALF_PI_Q30))
      else $error("elevation outside clamp");

   a_polar_clamp: assert property (@(posedge clock) disable iff (reset)
      valid_ff[ST_ANG] && pay_ff[ST_ANG].cmd == CMD_POLAR
      |-> (ang2_ff >= POLAR_EPS_Q30) && (ang2_ff <= PI_Q30 - POLAR_EPS_Q30))
      else $error("polar angle outside clamp");

   a_yaw_wrap: assert property (@(posedge clock) disable iff (reset)
      valid_ff[ST_ANG] && pay_ff[ST_ANG].cmd == CMD_YAW
      |-> (ang1_ff <= PI_Q30) && (ang1_ff >= -PI_Q30))
      else $error("yaw angle not wrapped");

endmodule
`default_nettype wire
